[hw/rtl/hprs_pkg.sv]
`default_nettype none

package hprs_pkg;

  localparam int RELAY_W    = 8;
  localparam int MODE_W     = 3;
  localparam int TEMP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int SEC_W      = 32;

  // relay positions, zero based
  localparam int PUMP_POS = 0;
  localparam int HP_POS   = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 3'd0,
    MODE_HP_ON    = 3'd1,
    MODE_HP_OFF   = 3'd2,
    MODE_PUMP_ON  = 3'd3,
    MODE_PUMP_OFF = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    BKUP_NONE  = 2'd0,
    BKUP_SUPPL = 2'd1,
    BKUP_REPL  = 2'd2
  } bkup_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKUP_MODE      = 2'd0,
    CFG_BACKUP_THRESHOLD = 2'd1,
    CFG_MIN_SWITCH       = 2'd2,
    CFG_BACKUP_RELAY     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               backup_mode;
    logic signed [TEMP_W-1:0] backup_threshold;
    logic [15:0]              min_switch_interval;
    logic [3:0]               backup_relay_index;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/hprs_cfg_regs.sv]
`default_nettype none

module hprs_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hprs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hprs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output hprs_pkg::cfg_t                   cfg_o
);
  import hprs_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BACKUP_MODE:      cfg_d.backup_mode         = cfg_data_i[1:0];
        CFG_BACKUP_THRESHOLD: cfg_d.backup_threshold    = cfg_data_i;
        CFG_MIN_SWITCH:       cfg_d.min_switch_interval = cfg_data_i;
        CFG_BACKUP_RELAY:     cfg_d.backup_relay_index  = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backup_mode         <= BKUP_NONE;
      cfg_q.backup_threshold    <= '0;
      cfg_q.min_switch_interval <= 16'd300;
      cfg_q.backup_relay_index  <= 4'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/hprs_core.sv]
`default_nettype none

module hprs_core #(
  parameter int NUM_RELAYS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [hprs_pkg::MODE_W-1:0]      mode_i,
  input  logic [hprs_pkg::TEMP_W-1:0]      outdoor_temp_i,
  input  logic                             tariff_allows_backup_i,
  input  hprs_pkg::cfg_t                   cfg_i,
  output logic [hprs_pkg::RELAY_W-1:0]     relay_next_o
);
  import hprs_pkg::*;

  localparam logic [RELAY_W-1:0] RelayMask =
    RELAY_W'((9'd1 << NUM_RELAYS) - 9'd1);

  logic [SEC_W-1:0]   sec_q, sec_d;
  logic [SEC_W-1:0]   last_q, last_d;
  logic [RELAY_W-1:0] bits_q, bits_d;

  logic [RELAY_W-1:0] bkup_bit;
  logic               delay_ok;
  logic               hp_req;
  logic               hp_tgt;
  logic               hp_chg;
  logic               temp_above;

  always_comb begin
    if (cfg_i.backup_relay_index == 4'd0 || int'(cfg_i.backup_relay_index) > NUM_RELAYS) begin
      bkup_bit = '0;
    end else begin
      bkup_bit = RELAY_W'(9'd1 << (cfg_i.backup_relay_index - 4'd1));
    end
  end

  // elapsed time wraps with the counters
  assign delay_ok   = (sec_q - last_q) >= {16'd0, cfg_i.min_switch_interval};
  assign temp_above = $signed(outdoor_temp_i) > $signed(cfg_i.backup_threshold);

  // at most one heat pump request per item
  always_comb begin
    hp_req = 1'b0;
    hp_tgt = 1'b0;
    case (mode_e'(mode_i))
      MODE_HP_ON: begin
        case (bkup_mode_e'(cfg_i.backup_mode))
          BKUP_NONE, BKUP_SUPPL: begin
            hp_req = 1'b1;
            hp_tgt = 1'b1;
          end
          BKUP_REPL: begin
            hp_req = 1'b1;
            hp_tgt = !tariff_allows_backup_i;
          end
          default: ;
        endcase
      end
      MODE_HP_OFF: begin
        hp_req = 1'b1;
        hp_tgt = 1'b0;
      end
      default: ;
    endcase
  end

  assign hp_chg = hp_req && (bits_q[HP_POS] != hp_tgt) && delay_ok;

  always_comb begin
    sec_d  = sec_q;
    last_d = last_q;
    bits_d = bits_q;
    if (hp_chg) begin
      last_d         = sec_q;
      bits_d[HP_POS] = hp_tgt;
    end
    case (mode_e'(mode_i))
      MODE_TICK: sec_d = sec_q + 32'd1;
      MODE_HP_ON: begin
        case (bkup_mode_e'(cfg_i.backup_mode))
          BKUP_SUPPL: begin
            if (!temp_above && tariff_allows_backup_i) begin
              if (bits_d[HP_POS]) bits_d = bits_d | bkup_bit;
            end else begin
              bits_d = bits_d & ~bkup_bit;
            end
          end
          BKUP_REPL: begin
            if (tariff_allows_backup_i) begin
              if (!bits_d[HP_POS]) bits_d = bits_d | bkup_bit;
            end else begin
              bits_d = bits_d & ~bkup_bit;
            end
          end
          default: ;
        endcase
      end
      MODE_PUMP_ON: bits_d[PUMP_POS] = 1'b1;
      MODE_PUMP_OFF: begin
        if (!bits_q[HP_POS] && ((bits_q & bkup_bit) == '0)) bits_d[PUMP_POS] = 1'b0;
      end
      default: ;
    endcase
    bits_d = bits_d & RelayMask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q  <= '0;
      last_q <= '0;
      bits_q <= '0;
    end else if (step_i) begin
      sec_q  <= sec_d;
      last_q <= last_d;
      bits_q <= bits_d;
    end
  end

  assign relay_next_o = bits_d;

  // a restart of the delay always records the current time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_q) |-> last_q == $past(sec_q))
    else $error("delay restarted with a wrong time");

  // the seconds counter only ever steps by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(sec_q) |-> sec_q == $past(sec_q) + 32'd1)
    else $error("seconds counter jumped");

endmodule

`default_nettype wire

[hw/rtl/heat_pump_relay_sequencer.sv]
// path: an accepted item is held in the input register, then goes through the
// relay logic into the result register
// throughput: one item per cycle; the stages stall only on m_axis_tready
// reset (rst_ni low, asynchronous): all relays off, seconds and last switch
// time zero, registers at their defaults, so the first heat pump change
// waits out the full switch interval
`default_nettype none

module heat_pump_relay_sequencer #(
  parameter int NUM_RELAYS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] outdoor_temp, [16] tariff_allows_backup, [23:17] zero
  input  logic [hprs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] mode
  input  logic [hprs_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] relay_states
  output logic [hprs_pkg::RELAY_W-1:0]     m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hprs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hprs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hprs_pkg::*;

  cfg_t cfg;

  logic               in_valid_q;
  logic [MODE_W-1:0]  in_mode_q;
  logic [TEMP_W-1:0]  in_temp_q;
  logic               in_tariff_q;
  logic               out_valid_q;
  logic [RELAY_W-1:0] out_data_q;
  logic [RELAY_W-1:0] relay_next;
  logic               out_free;
  logic               adv;
  logic               in_acc;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  hprs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hprs_core #(
    .NUM_RELAYS (NUM_RELAYS)
  ) u_core (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .step_i                 (adv),
    .mode_i                 (in_mode_q),
    .outdoor_temp_i         (in_temp_q),
    .tariff_allows_backup_i (in_tariff_q),
    .cfg_i                  (cfg),
    .relay_next_o           (relay_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_mode_q   <= s_axis_tuser;
      in_temp_q   <= s_axis_tdata[TEMP_W-1:0];
      in_tariff_q <= s_axis_tdata[TEMP_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_data_q <= relay_next;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a held item is not dropped while the result side is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_mode_q))
    else $error("stalled item lost");

  // every advance produces a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced item produced no result");

endmodule

`default_nettype wire

[dv/heat_pump_relay_sequencer_tb.sv]
`default_nettype none

module heat_pump_relay_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hprs_pkg::*;

  localparam int NUM_RELAYS = 8;
  localparam logic [1:0] BKUP_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [MODE_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [RELAY_W-1:0]    m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  heat_pump_relay_sequencer #(
    .NUM_RELAYS(NUM_RELAYS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // relay predictor state
  logic [SEC_W-1:0]          sec_count;
  logic [SEC_W-1:0]          last_hp_change;
  logic [RELAY_W-1:0]        relay_vec;
  logic [1:0]                bk_mode;
  logic signed [TEMP_W-1:0]  bk_thresh;
  logic [15:0]               min_gap;
  logic [3:0]                bk_idx;

  logic [RELAY_W-1:0] relay_q[$];
  int err_count;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("heat_pump_relay_sequencer_tb failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_idle_len(int pct);
    int r;
    r = $urandom_range(0, 99);
    if (r >= pct) return 0;
    if (r < 3) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [RELAY_W-1:0] backup_mask();
    if (bk_idx == 0 || bk_idx > NUM_RELAYS) return '0;
    return RELAY_W'(1) << (bk_idx - 1);
  endfunction

  // heat pump relay obeys the anti-short-cycle delay; no-op requests keep the timer
  function automatic void hp_request(logic on);
    logic [SEC_W-1:0] elapsed;
    elapsed = sec_count - last_hp_change;
    if (relay_vec[HP_POS] != on && elapsed >= SEC_W'(min_gap)) begin
      last_hp_change = sec_count;
      relay_vec[HP_POS] = on;
    end
  endfunction

  function automatic void backup_engage();
    if (bk_mode == BKUP_SUPPL) begin
      if (relay_vec[HP_POS]) relay_vec |= backup_mask();
    end else begin
      if (!relay_vec[HP_POS]) relay_vec |= backup_mask();
    end
  endfunction

  function automatic logic [RELAY_W-1:0] predict_relays(logic [MODE_W-1:0] mode,
                                                        logic signed [TEMP_W-1:0] temp,
                                                        logic tariff);
    case (mode)
      MODE_TICK: sec_count = sec_count + 1;
      MODE_HP_ON: begin
        case (bk_mode)
          BKUP_NONE: hp_request(1'b1);
          BKUP_SUPPL: begin
            hp_request(1'b1);
            if (temp > bk_thresh || !tariff) relay_vec &= ~backup_mask();
            else backup_engage();
          end
          BKUP_REPL: begin
            if (tariff) begin
              hp_request(1'b0);
              backup_engage();
            end else begin
              hp_request(1'b1);
              relay_vec &= ~backup_mask();
            end
          end
          default: ;
        endcase
      end
      MODE_HP_OFF: hp_request(1'b0);
      MODE_PUMP_ON: relay_vec[PUMP_POS] = 1'b1;
      MODE_PUMP_OFF: begin
        if (!relay_vec[HP_POS] && (relay_vec & backup_mask()) == '0)
          relay_vec[PUMP_POS] = 1'b0;
      end
      default: ;
    endcase
    return relay_vec;
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, logic signed [TEMP_W-1:0] temp,
                           logic tariff);
    int gap;
    gap = pick_idle_len(tx_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'b0, tariff, temp};
    do @(posedge clk_i); while (!s_axis_tready);
    relay_q.push_back(predict_relays(mode, temp, tariff));
  endtask

  // lets every pending item come back before the block is touched again
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (relay_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_BACKUP_MODE:      bk_mode   = val[1:0];
      CFG_BACKUP_THRESHOLD: bk_thresh = val;
      CFG_MIN_SWITCH:       min_gap   = val;
      CFG_BACKUP_RELAY:     bk_idx    = val[3:0];
      default: ;
    endcase
  endtask

  // result checker
  initial begin
    logic [RELAY_W-1:0] want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (relay_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected item: relay_states %02h", m_axis_tdata);
        end else begin
          want = relay_q.pop_front();
          if (m_axis_tdata !== want) begin
            err_count++;
            if (err_count <= 10)
              $display("relay_states mismatch: expected %02h actual %02h", want, m_axis_tdata);
          end
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        n = pick_idle_len(rx_idle_pct);
        if (n > 0) begin
          rx_stall_left = n - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // after reset the heat pump waits out the default delay
  task automatic test_reset_hold();
    send_item(MODE_HP_ON, 16'sh7fff, 1'b1);
    send_item(MODE_PUMP_ON, 16'sh0000, 1'b0);
    for (int m = MODE_PUMP_OFF + 1; m < 8; m++) send_item(MODE_W'(m), 16'sh8000, 1'b1);
    send_item(MODE_PUMP_OFF, 16'sh0000, 1'b0);
    send_item(MODE_TICK, 16'shffff, 1'b1);
  endtask

  task automatic test_supplement();
    write_reg(CFG_MIN_SWITCH, 16'd0);
    write_reg(CFG_BACKUP_MODE, CFG_DATA_W'(BKUP_SUPPL));
    write_reg(CFG_BACKUP_THRESHOLD, 16'd0);
    write_reg(CFG_BACKUP_RELAY, 16'd3);
    send_item(MODE_HP_ON, 16'sh8000, 1'b1);
    send_item(MODE_PUMP_ON, 16'sh0000, 1'b0);
    send_item(MODE_PUMP_OFF, 16'sh0000, 1'b0);
    send_item(MODE_HP_ON, 16'sh7fff, 1'b1);
    send_item(MODE_HP_ON, 16'sh0000, 1'b0);
    send_item(MODE_HP_ON, 16'sh0000, 1'b1);
    send_item(MODE_HP_OFF, 16'sh0000, 1'b0);
    send_item(MODE_PUMP_OFF, 16'sh0000, 1'b0);
  endtask

  task automatic test_replacement();
    write_reg(CFG_BACKUP_MODE, CFG_DATA_W'(BKUP_REPL));
    send_item(MODE_HP_ON, 16'sh0000, 1'b1);
    send_item(MODE_HP_ON, 16'sh0000, 1'b0);
    send_item(MODE_HP_ON, 16'sh0000, 1'b1);
    write_reg(CFG_BACKUP_MODE, CFG_DATA_W'(BKUP_UNUSED));
    send_item(MODE_HP_ON, 16'sh0000, 1'b0);
  endtask

  task automatic test_switch_delay();
    write_reg(CFG_BACKUP_MODE, CFG_DATA_W'(BKUP_NONE));
    write_reg(CFG_MIN_SWITCH, 16'd2);
    send_item(MODE_HP_ON, 16'sh0000, 1'b0);
    send_item(MODE_TICK, 16'sh0000, 1'b0);
    send_item(MODE_TICK, 16'sh0000, 1'b0);
    send_item(MODE_HP_ON, 16'sh0000, 1'b0);
    send_item(MODE_HP_OFF, 16'sh0000, 1'b0);
    send_item(MODE_TICK, 16'sh0000, 1'b0);
    send_item(MODE_HP_OFF, 16'sh0000, 1'b0);
  endtask

  // backup on the pump relay, on the heat pump relay, and on no relay
  task automatic test_shared_backup_relay();
    write_reg(CFG_BACKUP_MODE, CFG_DATA_W'(BKUP_SUPPL));
    write_reg(CFG_BACKUP_THRESHOLD, 16'h7fff);
    write_reg(CFG_MIN_SWITCH, 16'd0);
    write_reg(CFG_BACKUP_RELAY, 16'd1);
    send_item(MODE_HP_ON, 16'sh0000, 1'b1);
    send_item(MODE_PUMP_OFF, 16'sh0000, 1'b0);
    write_reg(CFG_BACKUP_RELAY, 16'd2);
    send_item(MODE_HP_ON, 16'sh0000, 1'b1);
    write_reg(CFG_BACKUP_RELAY, 16'd0);
    send_item(MODE_HP_ON, 16'sh0000, 1'b1);
    write_reg(CFG_BACKUP_RELAY, 16'd12);
    send_item(MODE_HP_ON, 16'sh0000, 1'b1);
  endtask

  task automatic send_random_item();
    int r;
    int t;
    logic [MODE_W-1:0] mode;
    logic signed [TEMP_W-1:0] temp;
    r = $urandom_range(0, 99);
    if (r < 35) mode = MODE_TICK;
    else if (r < 60) mode = MODE_HP_ON;
    else if (r < 75) mode = MODE_HP_OFF;
    else if (r < 85) mode = MODE_PUMP_ON;
    else if (r < 95) mode = MODE_PUMP_OFF;
    else mode = MODE_W'($urandom_range(MODE_PUMP_OFF + 1, 7));
    r = $urandom_range(0, 99);
    if (r < 10) temp = 16'sh8000;
    else if (r < 20) temp = 16'sh7fff;
    else if (r < 60) begin
      // close to the threshold, clamped to the field range
      t = int'(bk_thresh) + $urandom_range(0, 4) - 2;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      temp = TEMP_W'(t);
    end else temp = TEMP_W'($urandom_range(0, 16'hffff));
    send_item(mode, temp, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_phases();
    int r;
    logic [CFG_DATA_W-1:0] val;
    for (int ph = 0; ph < 10; ph++) begin
      r = $urandom_range(0, 99);
      if (r < 15) val = 16'd0;
      else if (r < 25) val = 16'hffff;
      else if (r < 35) val = 16'd300;
      else if (r < 45) val = CFG_DATA_W'($urandom_range(0, 16'hffff));
      else val = CFG_DATA_W'($urandom_range(1, 6));
      write_reg(CFG_MIN_SWITCH, val);
      r = $urandom_range(0, 99);
      if (r < 20) val = 16'h8000;
      else if (r < 40) val = 16'h7fff;
      else val = CFG_DATA_W'($urandom_range(0, 200) - 100);
      write_reg(CFG_BACKUP_THRESHOLD, val);
      r = $urandom_range(0, 99);
      val = (r < 10) ? CFG_DATA_W'(BKUP_UNUSED)
                     : CFG_DATA_W'($urandom_range(BKUP_NONE, BKUP_REPL));
      write_reg(CFG_BACKUP_MODE, val);
      r = $urandom_range(0, 99);
      val = (r < 70) ? CFG_DATA_W'($urandom_range(1, NUM_RELAYS))
                     : CFG_DATA_W'($urandom_range(0, 15));
      write_reg(CFG_BACKUP_RELAY, val);
      tx_idle_pct = (ph % 3 == 0) ? 0 : 30;
      rx_idle_pct = (ph % 4 == 1) ? 0 : 30;
      repeat (75) send_random_item();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_TICK;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_BACKUP_MODE;
    cfg_data_i    <= '0;
    err_count     = 0;
    rx_stall_left = 0;
    tx_idle_pct   = 30;
    rx_idle_pct   = 30;
    sec_count      = '0;
    last_hp_change = '0;
    relay_vec      = '0;
    bk_mode        = BKUP_NONE;
    bk_thresh      = '0;
    min_gap        = 16'd300;
    bk_idx         = 4'd3;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_hold();
    test_supplement();
    test_replacement();
    test_switch_delay();
    test_shared_backup_relay();
    test_random_phases();

    s_axis_tvalid <= 1'b0;
    while (relay_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && relay_q.size() == 0) begin
      $display("heat_pump_relay_sequencer_tb passed");
    end else begin
      $display("heat_pump_relay_sequencer_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/hprs_pkg.sv
hw/rtl/hprs_cfg_regs.sv
hw/rtl/hprs_core.sv
hw/rtl/heat_pump_relay_sequencer.sv
dv/heat_pump_relay_sequencer_tb.sv
